// File: rtl/cppcm_pkg.sv
// ----------------------------------------------------------------------------
// cppcm_pkg
// Shared types and constants of the circular pad plane channel mapper.
// ----------------------------------------------------------------------------
`default_nettype none

package cppcm_pkg;

    localparam int RADIUS_W   = 19;
    localparam int PITCH_W    = 16;
    localparam int PLANES_W   = 5;
    localparam int PLANE_W    = 4;
    localparam int REQ_W      = 2;
    localparam int STATUS_W   = 2;
    localparam int IDX_W      = 10;
    localparam int CHAN_W     = 24;
    localparam int PADS_W     = 20;
    localparam int CFG_IDX_W  = 2;
    localparam int SQ_W       = 2 * RADIUS_W;
    localparam int ROOT_W     = RADIUS_W;
    localparam int MUL_W      = 20;

    localparam int MAX_ROWS_DEF   = 1023;
    localparam int COORD_BITS_DEF = 20;

    localparam logic [REQ_W-1:0] REQ_BUILD  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_LOCATE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_MAP    = 2'd2;
    localparam logic [REQ_W-1:0] REQ_NONE   = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_PAD  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_RDY = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PITCH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PLANES = 2'd2;

    localparam logic [RADIUS_W-1:0] RADIUS_RST = 19'd0;
    localparam logic [PITCH_W-1:0]  PITCH_RST  = 16'd1024;
    localparam logic [PLANES_W-1:0] PLANES_RST = 5'd1;

    typedef enum logic [4:0] {
        S_IDLE,
        S_B_HDIV,
        S_B_HWAIT,
        S_B_R2,
        S_B_R2W,
        S_B_ROW,
        S_B_A,
        S_B_Y,
        S_B_SQ,
        S_B_LD,
        S_B_WR,
        S_L_XDIV,
        S_L_XWAIT,
        S_L_YDIV,
        S_L_YWAIT,
        S_M_CHK,
        S_M_RD,
        S_M_LIM,
        S_M_SUM,
        S_DONE
    } state_t;

endpackage

`default_nettype wire

// File: rtl/circular_pad_plane_channel_mapper_top.sv
// ----------------------------------------------------------------------------
// circular_pad_plane_channel_mapper_top
// Maps pads of a circular pad plane to flat channel numbers.
// ----------------------------------------------------------------------------
// Map: range check, table read, limit check, channel sum. Locate: serial row
// and column divides, then the map steps. W, the divider width, is
// max(COORD_BITS+2,19). Build: a half-row divide, then per row a 19-step root
// then W-step divide (neither for an empty row), over 2H+1 rows. One item at
// a time; ready again once the result sits in the output register. Reset:
// async, resets control registers; marks row tables not built, not cleared.
`default_nettype none

module circular_pad_plane_channel_mapper_top
    import cppcm_pkg::*;
#(
    parameter int MAX_ROWS   = MAX_ROWS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic [CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [RADIUS_W-1:0]         cfg_wdata,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic [REQ_W-1:0]            req_type,
    input  wire logic [PLANE_W-1:0]          plane,
    input  wire logic signed [COORD_BITS-1:0] pos_x,
    input  wire logic signed [COORD_BITS-1:0] pos_y,
    input  wire logic signed [IDX_W-1:0]     row_index,
    input  wire logic signed [IDX_W-1:0]     col_index,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic      [STATUS_W-1:0]         status,
    output logic signed [IDX_W-1:0]          row_out,
    output logic signed [IDX_W-1:0]          col_out,
    output logic      [CHAN_W-1:0]           channel,
    output logic      [PADS_W-1:0]           pads_per_plane
);

    localparam int HW   = $clog2(MAX_ROWS + 1);
    localparam int AW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int HMAX = (MAX_ROWS - 1) / 2;
    localparam int NW   = (COORD_BITS + 2 > 18) ? COORD_BITS + 2 : 18;
    localparam int DIVW = (NW > RADIUS_W) ? NW : RADIUS_W;
    localparam int DENW = PITCH_W + 1;
    localparam int SW   = DIVW + 1;
    localparam int LIMW = HW + 1;
    localparam int PW   = 2 * MUL_W;

    state_t state_reg, state_next;

    logic [RADIUS_W-1:0] radius_reg, radius_next;
    logic [PITCH_W-1:0]  pitch_reg, pitch_next;
    logic [PLANES_W-1:0] planes_reg, planes_next;

    logic [HW-1:0]     half_rows_reg, half_rows_next;
    logic [PADS_W-1:0] pad_total_reg, pad_total_next;
    logic              ready_reg, ready_next;

    logic [HW-1:0]      hb_reg, hb_next;
    logic [HW-1:0]      i_reg, i_next;
    logic [PADS_W-1:0]  total_reg, total_next;
    logic signed [LIMW-1:0] lim_reg, lim_next;
    logic [SQ_W-1:0]    r2_reg, r2_next;
    logic [PW-1:0]      prod_reg;
    logic [AW-1:0]      addr_reg, addr_next;

    logic [REQ_W-1:0]   req_reg, req_next;
    logic [PLANE_W-1:0] plane_reg, plane_next;
    logic signed [COORD_BITS-1:0] px_reg, px_next;
    logic signed [COORD_BITS-1:0] py_reg, py_next;
    logic signed [SW-1:0] row_reg, row_next;
    logic signed [SW-1:0] col_reg, col_next;
    logic [STATUS_W-1:0] st_reg, st_next;
    logic [CHAN_W-1:0]   chan_reg, chan_next;

    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic signed [IDX_W-1:0] row_out_reg, row_out_next;
    logic signed [IDX_W-1:0] col_out_reg, col_out_next;
    logic [CHAN_W-1:0]   channel_reg, channel_next;
    logic [PADS_W-1:0]   pads_reg, pads_next;

    logic [MUL_W-1:0] mul_a, mul_b;

    logic            div_start, div_done, div_nz;
    logic [DIVW-1:0] div_num, div_quo;
    logic [DENW-1:0] div_den;

    logic              sq_start, sq_done;
    logic [ROOT_W-1:0] sq_root;

    logic                   mem_we;
    logic [LIMW-1:0]        lim_rdata;
    logic [PADS_W-1:0]      start_rdata;

    logic                  in_acc;
    logic signed [HW:0]    rel_row;
    logic [HW-1:0]         abs_row;
    logic signed [NW-1:0]  nx, ny;
    logic [NW-1:0]         magx, magy;
    logic [SW-1:0]         qadj;
    logic signed [SW-1:0]  qsigned;
    logic signed [SW-1:0]  hs;
    logic signed [SW-1:0]  lim_s;
    logic [SQ_W-1:0]       y2;

    cppcm_div #(.NW(DIVW), .DW(DENW)) u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .num    (div_num),
        .den    (div_den),
        .done   (div_done),
        .quo    (div_quo),
        .rem_nz (div_nz)
    );

    cppcm_isqrt u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sq_start),
        .val   (y2),
        .done  (sq_done),
        .root  (sq_root)
    );

    cppcm_ram #(.WIDTH(LIMW), .DEPTH(MAX_ROWS)) u_lim_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (i_reg[AW-1:0]),
        .wdata (lim_reg),
        .raddr (addr_reg),
        .rdata (lim_rdata)
    );

    cppcm_ram #(.WIDTH(PADS_W), .DEPTH(MAX_ROWS)) u_start_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (i_reg[AW-1:0]),
        .wdata (total_reg),
        .raddr (addr_reg),
        .rdata (start_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            radius_reg    <= RADIUS_RST;
            pitch_reg     <= PITCH_RST;
            planes_reg    <= PLANES_RST;
            half_rows_reg <= '0;
            pad_total_reg <= '0;
            ready_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            radius_reg    <= radius_next;
            pitch_reg     <= pitch_next;
            planes_reg    <= planes_next;
            half_rows_reg <= half_rows_next;
            pad_total_reg <= pad_total_next;
            ready_reg     <= ready_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hb_reg      <= hb_next;
        i_reg       <= i_next;
        total_reg   <= total_next;
        lim_reg     <= lim_next;
        r2_reg      <= r2_next;
        prod_reg    <= PW'(mul_a) * PW'(mul_b);
        addr_reg    <= addr_next;
        req_reg     <= req_next;
        plane_reg   <= plane_next;
        px_reg      <= px_next;
        py_reg      <= py_next;
        row_reg     <= row_next;
        col_reg     <= col_next;
        st_reg      <= st_next;
        chan_reg    <= chan_next;
        status_reg  <= status_next;
        row_out_reg <= row_out_next;
        col_out_reg <= col_out_next;
        channel_reg <= channel_next;
        pads_reg    <= pads_next;
    end

    always_comb
    begin
        radius_next = radius_reg;
        pitch_next  = pitch_reg;
        planes_next = planes_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_RADIUS: radius_next = cfg_wdata;
                CFG_PITCH:  pitch_next  = cfg_wdata[PITCH_W-1:0];
                CFG_PLANES: planes_next = cfg_wdata[PLANES_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        in_acc  = in_valid && (state_reg == S_IDLE);
        rel_row = $signed({1'b0, i_reg}) - $signed({1'b0, hb_reg});
        abs_row = rel_row[HW] ? HW'(-rel_row) : HW'(rel_row);
        nx      = (NW'(px_reg) <<< 1) + NW'($signed({1'b0, pitch_reg}));
        ny      = (NW'(py_reg) <<< 1) + NW'($signed({1'b0, pitch_reg}));
        magx    = nx[NW-1] ? $unsigned(-nx) : $unsigned(nx);
        magy    = ny[NW-1] ? $unsigned(-ny) : $unsigned(ny);
        qadj    = SW'(div_quo) + SW'(div_nz);
        hs      = $signed(SW'(half_rows_reg));
        lim_s   = SW'($signed(lim_rdata));
        y2      = r2_reg - prod_reg[SQ_W-1:0];

        state_next     = state_reg;
        half_rows_next = half_rows_reg;
        pad_total_next = pad_total_reg;
        ready_next     = ready_reg;
        hb_next        = hb_reg;
        i_next         = i_reg;
        total_next     = total_reg;
        lim_next       = lim_reg;
        r2_next        = r2_reg;
        addr_next      = addr_reg;
        req_next       = req_reg;
        plane_next     = plane_reg;
        px_next        = px_reg;
        py_next        = py_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        st_next        = st_reg;
        chan_next      = chan_reg;
        qsigned        = $signed(qadj);

        out_valid_next = out_valid_reg && out_stall;
        status_next    = status_reg;
        row_out_next   = row_out_reg;
        col_out_next   = col_out_reg;
        channel_next   = channel_reg;
        pads_next      = pads_reg;

        mul_a     = '0;
        mul_b     = '0;
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        sq_start  = 1'b0;
        mem_we    = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    req_next   = req_type;
                    plane_next = plane;
                    px_next    = pos_x;
                    py_next    = pos_y;
                    row_next   = '0;
                    col_next   = '0;
                    chan_next  = '0;
                    st_next    = ST_OK;
                    case (req_type)
                        REQ_BUILD:
                        begin
                            ready_next     = 1'b0;
                            half_rows_next = '0;
                            pad_total_next = '0;
                            if (pitch_reg == '0)
                            begin
                                st_next    = ST_NOT_RDY;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                state_next = S_B_HDIV;
                            end
                        end
                        REQ_LOCATE:
                        begin
                            if (!ready_reg || pitch_reg == '0)
                            begin
                                st_next    = ST_NOT_RDY;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                state_next = S_L_XDIV;
                            end
                        end
                        REQ_MAP:
                        begin
                            row_next = SW'(row_index);
                            col_next = SW'(col_index);
                            if (!ready_reg)
                            begin
                                st_next    = ST_NOT_RDY;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                state_next = S_M_CHK;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_B_HDIV:
            begin
                div_start  = 1'b1;
                div_num    = DIVW'(radius_reg);
                div_den    = DENW'(pitch_reg);
                state_next = S_B_HWAIT;
            end
            S_B_HWAIT:
            begin
                if (div_done)
                begin
                    if (div_quo > DIVW'(HMAX))
                    begin
                        st_next    = ST_NOT_RDY;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        hb_next    = div_quo[HW-1:0];
                        i_next     = '0;
                        total_next = '0;
                        state_next = S_B_R2;
                    end
                end
            end
            S_B_R2:
            begin
                mul_a      = MUL_W'(radius_reg);
                mul_b      = MUL_W'(radius_reg);
                state_next = S_B_R2W;
            end
            S_B_R2W:
            begin
                r2_next    = prod_reg[SQ_W-1:0];
                state_next = S_B_ROW;
            end
            S_B_ROW:
            begin
                mul_a      = MUL_W'(abs_row);
                mul_b      = MUL_W'(pitch_reg);
                state_next = S_B_A;
            end
            S_B_A:
            begin
                mul_a = prod_reg[MUL_W-1:0];
                mul_b = prod_reg[MUL_W-1:0];
                if (prod_reg >= PW'(radius_reg))
                begin
                    lim_next   = '1;
                    state_next = S_B_WR;
                end
                else
                begin
                    state_next = S_B_Y;
                end
            end
            S_B_Y:
            begin
                if (y2 == '0)
                begin
                    lim_next   = '1;
                    state_next = S_B_WR;
                end
                else
                begin
                    sq_start   = 1'b1;
                    state_next = S_B_SQ;
                end
            end
            S_B_SQ:
            begin
                if (sq_done)
                begin
                    div_start  = 1'b1;
                    div_num    = DIVW'(sq_root);
                    div_den    = DENW'(pitch_reg);
                    state_next = S_B_LD;
                end
            end
            S_B_LD:
            begin
                if (div_done)
                begin
                    lim_next   = $signed(LIMW'(div_quo));
                    state_next = S_B_WR;
                end
            end
            S_B_WR:
            begin
                mem_we = 1'b1;
                if (!lim_reg[LIMW-1])
                begin
                    total_next = total_reg + PADS_W'({lim_reg, 1'b1});
                end
                if ((HW + 1)'(i_reg) == ((HW + 1)'(hb_reg) << 1))
                begin
                    half_rows_next = hb_reg;
                    pad_total_next = total_next;
                    ready_next     = 1'b1;
                    st_next        = ST_OK;
                    state_next     = S_DONE;
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_B_ROW;
                end
            end
            S_L_XDIV:
            begin
                div_start  = 1'b1;
                div_num    = DIVW'(magx);
                div_den    = {pitch_reg, 1'b0};
                state_next = S_L_XWAIT;
            end
            S_L_XWAIT:
            begin
                if (div_done)
                begin
                    row_next   = nx[NW-1] ? -qsigned : $signed(SW'(div_quo));
                    state_next = S_L_YDIV;
                end
            end
            S_L_YDIV:
            begin
                div_start  = 1'b1;
                div_num    = DIVW'(magy);
                div_den    = {pitch_reg, 1'b0};
                state_next = S_L_YWAIT;
            end
            S_L_YWAIT:
            begin
                if (div_done)
                begin
                    col_next   = ny[NW-1] ? -qsigned : $signed(SW'(div_quo));
                    state_next = S_M_CHK;
                end
            end
            S_M_CHK:
            begin
                addr_next = AW'(row_reg + hs);
                if (PLANES_W'(plane_reg) >= planes_reg || row_reg > hs || row_reg < -hs)
                begin
                    st_next    = ST_NO_PAD;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_M_RD;
                end
            end
            S_M_RD:
            begin
                state_next = S_M_LIM;
            end
            S_M_LIM:
            begin
                mul_a = MUL_W'(plane_reg);
                mul_b = MUL_W'(pad_total_reg);
                if (col_reg >= -lim_s && col_reg <= lim_s)
                begin
                    state_next = S_M_SUM;
                end
                else
                begin
                    st_next    = ST_NO_PAD;
                    state_next = S_DONE;
                end
            end
            S_M_SUM:
            begin
                chan_next  = prod_reg[CHAN_W-1:0] + CHAN_W'(start_rdata)
                           + CHAN_W'(col_reg) + CHAN_W'(lim_s);
                st_next    = ST_OK;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    status_next    = st_reg;
                    if (row_reg < -SW'(512))
                        row_out_next = -IDX_W'(512);
                    else if (row_reg > SW'(511))
                        row_out_next = IDX_W'(511);
                    else
                        row_out_next = row_reg[IDX_W-1:0];
                    if (col_reg < -SW'(512))
                        col_out_next = -IDX_W'(512);
                    else if (col_reg > SW'(511))
                        col_out_next = IDX_W'(511);
                    else
                        col_out_next = col_reg[IDX_W-1:0];
                    channel_next   = (st_reg == ST_OK) ? chan_reg : '0;
                    pads_next      = pad_total_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_stall       = (state_reg != S_IDLE);
    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign row_out        = row_out_reg;
    assign col_out        = col_out_reg;
    assign channel        = channel_reg;
    assign pads_per_plane = pads_reg;

    property p_half_rows_bound;
        @(posedge clk) disable iff (!rst_n)
            ready_reg |-> (half_rows_reg <= HW'(HMAX));
    endproperty
    a_half_rows_bound: assert property (p_half_rows_bound)
        else $error("half row count beyond row store");

    property p_lookup_needs_tables;
        @(posedge clk) disable iff (!rst_n)
            (state_reg == S_M_CHK) |-> ready_reg;
    endproperty
    a_lookup_needs_tables: assert property (p_lookup_needs_tables)
        else $error("lookup started without built tables");

    property p_ready_from_build;
        @(posedge clk) disable iff (!rst_n)
            $rose(ready_reg) |-> ($past(state_reg) == S_B_WR);
    endproperty
    a_ready_from_build: assert property (p_ready_from_build)
        else $error("tables marked built outside a build");

    property p_write_in_range;
        @(posedge clk) disable iff (!rst_n)
            mem_we |-> ((HW + 1)'(i_reg) <= ((HW + 1)'(hb_reg) << 1));
    endproperty
    a_write_in_range: assert property (p_write_in_range)
        else $error("row table write beyond built rows");

endmodule

`default_nettype wire

// File: rtl/cppcm_ram.sv
// ----------------------------------------------------------------------------
// cppcm_ram
// Generic single write port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module cppcm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: rtl/cppcm_div.sv
// ----------------------------------------------------------------------------
// cppcm_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module cppcm_div
    import cppcm_pkg::*;
#(
    parameter int NW = 22,
    parameter int DW = 17
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [NW-1:0] num,
    input  wire logic [DW-1:0] den,
    output logic               done,
    output logic      [NW-1:0] quo,
    output logic               rem_nz
);

    localparam int CW = $clog2(NW + 1);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [NW-1:0] quo_reg, quo_next;
    logic [DW-1:0] rem_reg, rem_next;
    logic [DW-1:0] den_reg, den_next;
    logic [DW:0]   rem_s;
    logic          ge;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    always_comb
    begin
        rem_s     = {rem_reg, quo_reg[NW-1]};
        ge        = (rem_s >= {1'b0, den_reg});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = num;
            rem_next  = '0;
            den_next  = den;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[NW-2:0], ge};
            rem_next = ge ? DW'(rem_s - {1'b0, den_reg}) : rem_s[DW-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(NW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign done   = done_reg;
    assign quo    = quo_reg;
    assign rem_nz = (rem_reg != '0);

    property p_done_after_busy;
        @(posedge clk) disable iff (!rst_n) done_reg |-> $past(busy_reg);
    endproperty
    a_done_after_busy: assert property (p_done_after_busy)
        else $error("divider done without a run");

    property p_cnt_bound;
        @(posedge clk) disable iff (!rst_n) busy_reg |-> (cnt_reg < CW'(NW));
    endproperty
    a_cnt_bound: assert property (p_cnt_bound)
        else $error("divider step count overrun");

    property p_rem_bound;
        @(posedge clk) disable iff (!rst_n) done_reg |-> (rem_reg < den_reg);
    endproperty
    a_rem_bound: assert property (p_rem_bound)
        else $error("divider remainder not below divisor");

endmodule

`default_nettype wire

// File: rtl/cppcm_isqrt.sv
// ----------------------------------------------------------------------------
// cppcm_isqrt
// Integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module cppcm_isqrt
    import cppcm_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [SQ_W-1:0]   val,
    output logic                   done,
    output logic      [ROOT_W-1:0] root
);

    localparam int CW = $clog2(ROOT_W + 1);
    localparam int RW = ROOT_W + 3;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [SQ_W-1:0]   val_reg, val_next;
    logic [RW-1:0]     rem_reg, rem_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic [RW-1:0]     rem_s;
    logic [RW-1:0]     trial;
    logic              ge;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg  <= val_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    always_comb
    begin
        rem_s     = {rem_reg[RW-3:0], val_reg[SQ_W-1:SQ_W-2]};
        trial     = RW'({root_reg, 2'b01});
        ge        = (rem_s >= trial);
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        val_next  = val_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            val_next  = val;
            rem_next  = '0;
            root_next = '0;
        end
        else if (busy_reg)
        begin
            val_next  = {val_reg[SQ_W-3:0], 2'b00};
            rem_next  = ge ? (rem_s - trial) : rem_s;
            root_next = {root_reg[ROOT_W-2:0], ge};
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == CW'(ROOT_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;

    property p_done_after_busy;
        @(posedge clk) disable iff (!rst_n) done_reg |-> $past(busy_reg);
    endproperty
    a_done_after_busy: assert property (p_done_after_busy)
        else $error("root done without a run");

    property p_no_restart;
        @(posedge clk) disable iff (!rst_n) busy_reg |-> !start;
    endproperty
    a_no_restart: assert property (p_no_restart)
        else $error("root unit restarted while busy");

    property p_cnt_bound;
        @(posedge clk) disable iff (!rst_n) busy_reg |-> (cnt_reg < CW'(ROOT_W));
    endproperty
    a_cnt_bound: assert property (p_cnt_bound)
        else $error("root step count overrun");

endmodule

`default_nettype wire
